FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent checks clocked on clk, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Same, with antecedent and consequent given by the caller; the macro writes the implication.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: design/vdas_pkg.sv
`default_nettype none
package vdas_pkg;

	localparam int CordicSteps = 16;
	localparam int TabLen      = 24;
	localparam int CordicIters = (CordicSteps < TabLen) ? CordicSteps : TabLen;
	localparam int XyW         = 52;
	localparam int ZW          = 26;
	localparam logic signed [ZW-1:0] Deg90 = 26'sd5898240;

	localparam logic [1:0] ModeFront = 2'd0;
	localparam logic [1:0] ModeRear  = 2'd1;

	localparam logic [2:0] RegMode  = 3'd0;
	localparam logic [2:0] RegTorq  = 3'd1;
	localparam logic [2:0] RegRate  = 3'd2;
	localparam logic [2:0] RegMaxSt = 3'd3;
	localparam logic [2:0] RegWb    = 3'd4;
	localparam logic [2:0] RegTrack = 3'd5;

	typedef struct packed {
		logic [1:0]  drive_mode;
		logic [15:0] drive_torque;
		logic [15:0] steer_rate;
		logic [14:0] max_steer_angle;
		logic [15:0] wheelbase;
		logic [15:0] track;
	} cfg_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		case (idx)
			5'd0:  r = 26'sd2949120;
			5'd1:  r = 26'sd1740967;
			5'd2:  r = 26'sd919879;
			5'd3:  r = 26'sd466945;
			5'd4:  r = 26'sd234379;
			5'd5:  r = 26'sd117304;
			5'd6:  r = 26'sd58666;
			5'd7:  r = 26'sd29335;
			5'd8:  r = 26'sd14668;
			5'd9:  r = 26'sd7334;
			5'd10: r = 26'sd3667;
			5'd11: r = 26'sd1833;
			5'd12: r = 26'sd917;
			5'd13: r = 26'sd458;
			5'd14: r = 26'sd229;
			5'd15: r = 26'sd115;
			5'd16: r = 26'sd57;
			5'd17: r = 26'sd29;
			5'd18: r = 26'sd14;
			5'd19: r = 26'sd7;
			5'd20: r = 26'sd4;
			5'd21: r = 26'sd2;
			5'd22: r = 26'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		logic signed [15:0] r;
		if (v > 34'sd32767)
			r = 16'sh7fff;
		else if (v < -34'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/vdas_regs.sv
`default_nettype none
module vdas_regs
	import vdas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output cfg_t             cfg
);

	cfg_t cfg_q;
	logic [2:0] idx;

	assign idx = paddr[4:2];
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_mode      <= 2'd2;
			cfg_q.drive_torque    <= '0;
			cfg_q.steer_rate      <= '0;
			cfg_q.max_steer_angle <= '0;
			cfg_q.wheelbase       <= 16'd2500;
			cfg_q.track           <= 16'd1500;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				RegMode:  cfg_q.drive_mode      <= pwdata[1:0];
				RegTorq:  cfg_q.drive_torque    <= pwdata[15:0];
				RegRate:  cfg_q.steer_rate      <= pwdata[15:0];
				RegMaxSt: cfg_q.max_steer_angle <= pwdata[14:0];
				RegWb:    cfg_q.wheelbase       <= pwdata[15:0];
				RegTrack: cfg_q.track           <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegMode:  prdata = {30'd0, cfg_q.drive_mode};
			RegTorq:  prdata = {16'd0, cfg_q.drive_torque};
			RegRate:  prdata = {16'd0, cfg_q.steer_rate};
			RegMaxSt: prdata = {17'd0, cfg_q.max_steer_angle};
			RegWb:    prdata = {16'd0, cfg_q.wheelbase};
			RegTrack: prdata = {16'd0, cfg_q.track};
			default:  prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: design/vdas_cordic_step.sv
`default_nettype none
module vdas_cordic_step
	import vdas_pkg::*;
(
	input  wire logic                  vec,
	input  wire logic [4:0]            idx,
	input  wire logic signed [XyW-1:0] x,
	input  wire logic signed [XyW-1:0] y,
	input  wire logic signed [ZW-1:0]  z,
	output logic signed [XyW-1:0]      nx,
	output logic signed [XyW-1:0]      ny,
	output logic signed [ZW-1:0]       nz
);

	logic signed [XyW-1:0] sx, sy;
	logic signed [ZW-1:0]  a;
	logic                  neg;

	assign sx  = x >>> idx;
	assign sy  = y >>> idx;
	assign a   = atan_lut(idx);
	// rotate toward z = 0, or vector toward y = 0
	assign neg = vec ? !y[XyW-1] : z[ZW-1];

	always_comb begin
		if (neg) begin
			nx = x + sy;
			ny = y - sx;
			nz = z + a;
		end else begin
			nx = x - sy;
			ny = y + sx;
			nz = z - a;
		end
	end

endmodule
`default_nettype wire

FILE: design/vehicle_drive_and_ackermann_steer.sv
// Channel | Signals                                           | Direction
// in      | in_valid/in_ready, time_step, target_throttle,    | item in
//         | target_steering, handbrake_level                  |
// out     | out_valid/out_ready, front_torque, rear_torque,   | item out
//         | rear_lock, left_steer_angle, right_steer_angle    |
// cfg     | psel, penable, pwrite, paddr, pwdata, prdata      | APB registers
// An item skips the CORDIC when the inner angle is zero; else the shared CORDIC step
// unit runs twice in sequence, first rotating and then vectoring.
// One shared 17x33 multiplier serves the slew limit, torque, angle and
// Ackermann products. in_ready is high only while idle; a finished item waits
// in the output register and blocks the next only if still not taken.
// arst_n clears state, slew values and registers to their reset values.
`default_nettype none
module vehicle_drive_and_ackermann_steer
	import vdas_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] time_step,
	input  wire logic signed [15:0] target_throttle,
	input  wire logic signed [15:0] target_steering,
	input  wire logic [7:0]  handbrake_level,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [15:0] front_torque,
	output logic signed [15:0] rear_torque,
	output logic             rear_lock,
	output logic signed [15:0] left_steer_angle,
	output logic signed [15:0] right_steer_angle
);

	typedef enum logic [3:0] {
		S_IDLE, S_LIM, S_SLEW, S_TRQ, S_ALPHA, S_CINIT, S_ROT,
		S_MWY, S_MTX, S_MTY, S_VINIT, S_VEC, S_DONE
	} state_t;

	cfg_t cfg;
	state_t state_q;

	logic [15:0]        ts_q;
	logic signed [15:0] tthr_q, tstr_q, thr_q, str_q;
	logic               lock_q;
	logic signed [49:0] p_q;
	logic signed [XyW-1:0] x_q, y_q, acc_q;
	logic signed [ZW-1:0]  z_q;
	logic [4:0]         cnt_q;
	logic [14:0]        alpha_q;
	logic signed [15:0] torque_q;
	logic               out_valid_q, lock_out_q;
	logic signed [15:0] ftq_q, rtq_q, left_q, right_q;

	logic signed [16:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [49:0] mul_p;
	logic signed [XyW-1:0] nx, ny;
	logic signed [ZW-1:0]  nz;

	logic front, rear, both;
	logic signed [24:0] thr_d, thr_lim, str_d, str_lim;
	logic signed [15:0] thr_new, str_new;
	logic [16:0]        str_mag;
	logic [33:0]        tmag, tround;
	logic signed [33:0] tq;
	logic [30:0]        alpha_sum;
	logic signed [ZW-1:0] z0, zr;
	logic signed [15:0] beta, left_n, right_n;
	logic               last;

	vdas_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg)
	);

	vdas_cordic_step u_step (
		.vec(state_q == S_VEC), .idx(cnt_q), .x(x_q), .y(y_q), .z(z_q),
		.nx(nx), .ny(ny), .nz(nz)
	);

	assign pready    = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign front_torque      = ftq_q;
	assign rear_torque       = rtq_q;
	assign rear_lock         = lock_out_q;
	assign left_steer_angle  = left_q;
	assign right_steer_angle = right_q;

	assign front = (cfg.drive_mode != ModeRear);
	assign rear  = (cfg.drive_mode != ModeFront);
	assign both  = front && rear;
	assign last  = (cnt_q == 5'(CordicIters - 1));

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_LIM:   begin mul_a = {1'b0, ts_q};               mul_b = {17'd0, cfg.steer_rate}; end
			S_TRQ:   begin mul_a = {1'b0, cfg.drive_torque};   mul_b = 33'(thr_q); end
			S_ALPHA: begin mul_a = {2'b0, cfg.max_steer_angle}; mul_b = {16'd0, str_mag}; end
			S_MWY:   begin mul_a = {1'b0, cfg.wheelbase};      mul_b = y_q[32:0]; end
			S_MTX:   begin mul_a = {1'b0, cfg.track};          mul_b = x_q[32:0]; end
			default: begin mul_a = {1'b0, cfg.track};          mul_b = y_q[32:0]; end
		endcase
	end
	assign mul_p = 50'(mul_a) * 50'(mul_b);

	// slew limiting
	always_comb begin
		thr_lim = {8'd0, ts_q, 1'b0};
		thr_d   = 25'(tthr_q) - 25'(thr_q);
		if (thr_d > thr_lim)
			thr_d = thr_lim;
		if (thr_d < -thr_lim)
			thr_d = -thr_lim;
		thr_new = 16'(25'(thr_q) + thr_d);
		str_lim = {2'b0, p_q[31:9]};
		str_d   = 25'(tstr_q) - 25'(str_q);
		if (str_d > str_lim)
			str_d = str_lim;
		if (str_d < -str_lim)
			str_d = -str_lim;
		str_new = 16'(25'(str_q) + str_d);
	end

	assign str_mag = str_q[15] ? 17'(-18'(str_q)) : {1'b0, str_q};

	// torque round half away from zero
	always_comb begin
		tmag   = p_q[32] ? -p_q[33:0] : p_q[33:0];
		tround = both ? ((tmag + 34'd32768) >> 16) : ((tmag + 34'd16384) >> 15);
		tq     = p_q[32] ? -34'(tround) : 34'(tround);
	end

	assign alpha_sum = p_q[30:0] + 31'd16384;
	assign z0 = 26'({alpha_sum[29:15], 8'd0});

	always_comb begin
		zr = (z_q + 26'sd128) >>> 8;
		beta = (alpha_q == '0) ? 16'sd0 : sat16(34'(zr));
		if (str_q > 16'sd0) begin
			left_n  = 16'({1'b0, alpha_q});
			right_n = beta;
		end else begin
			right_n = -16'({1'b0, alpha_q});
			left_n  = sat16(-34'(beta));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= '0;
			str_q       <= '0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ts_q    <= time_step;
						tthr_q  <= target_throttle;
						tstr_q  <= target_steering;
						lock_q  <= (handbrake_level > 8'd128);
						state_q <= S_LIM;
					end
				end
				S_LIM: begin
					p_q     <= mul_p;
					state_q <= S_SLEW;
				end
				S_SLEW: begin
					thr_q   <= thr_new;
					str_q   <= str_new;
					state_q <= S_TRQ;
				end
				S_TRQ: begin
					p_q     <= mul_p;
					state_q <= S_ALPHA;
				end
				S_ALPHA: begin
					torque_q <= sat16(tq);
					p_q      <= mul_p;
					state_q  <= S_CINIT;
				end
				S_CINIT: begin
					alpha_q <= alpha_sum[29:15];
					cnt_q   <= '0;
					if (z0 > Deg90) begin
						x_q <= '0;
						y_q <= XyW'(1) <<< 28;
						z_q <= z0 - Deg90;
					end else begin
						x_q <= XyW'(1) <<< 28;
						y_q <= '0;
						z_q <= z0;
					end
					state_q <= (alpha_sum[29:15] == '0) ? S_DONE : S_ROT;
				end
				S_ROT: begin
					x_q   <= nx;
					y_q   <= ny;
					z_q   <= nz;
					cnt_q <= cnt_q + 5'd1;
					if (last)
						state_q <= S_MWY;
				end
				S_MWY: begin
					p_q     <= mul_p;
					state_q <= S_MTX;
				end
				S_MTX: begin
					acc_q   <= XyW'(p_q);
					p_q     <= mul_p;
					state_q <= S_MTY;
				end
				S_MTY: begin
					acc_q   <= acc_q + XyW'(p_q);
					p_q     <= mul_p;
					state_q <= S_VINIT;
				end
				S_VINIT: begin
					cnt_q <= '0;
					if (acc_q[XyW-1]) begin
						x_q <= XyW'(p_q);
						y_q <= -acc_q;
						z_q <= Deg90;
					end else begin
						x_q <= acc_q;
						y_q <= XyW'(p_q);
						z_q <= '0;
					end
					state_q <= S_VEC;
				end
				S_VEC: begin
					x_q   <= nx;
					y_q   <= ny;
					z_q   <= nz;
					cnt_q <= cnt_q + 5'd1;
					if (last)
						state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						ftq_q       <= front ? torque_q : 16'sd0;
						rtq_q       <= rear ? torque_q : 16'sd0;
						lock_out_q  <= lock_q;
						left_q      <= left_n;
						right_q     <= right_n;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: design/vdas_checker.sv
`default_nettype none
`include "assert_macros.svh"
module vdas_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] left_steer_angle,
	input wire logic [15:0] right_steer_angle
);

	// one item at a time: busy right after taking an item
	`ASSERT_IMP(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready after accept")
	// no result can appear the cycle after an item is taken
	`ASSERT_IMP(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")
	// stalled result holds
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(left_steer_angle) && $stable(right_steer_angle), "output changed while stalled")

endmodule

bind vehicle_drive_and_ackermann_steer vdas_checker u_vdas_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready),
	.left_steer_angle(left_steer_angle), .right_steer_angle(right_steer_angle)
);
`default_nettype wire
